// ----- sv/acwba_pkg.sv -----
// ----------------------------------------------------------------------------
// acwba_pkg
// shared types and codes for the alarm clock with button adjust
// ----------------------------------------------------------------------------
package acwba_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SNOOZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 1'd1;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  localparam logic [1:0] BTN_MODE   = 2'd0;
  localparam logic [1:0] BTN_ALARM  = 2'd1;
  localparam logic [1:0] BTN_INCR   = 2'd2;
  localparam logic [1:0] BTN_SNOOZE = 2'd3;

  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;
  localparam logic [2:0] WDAY_LAST = 3'd6;
  localparam logic [6:0] MIN_WRAP  = 7'd60;
  localparam logic [6:0] MIN_WRAP2 = 7'd120;
  localparam logic [4:0] HOUR_WRAP = 5'd24;
  localparam logic [4:0] HALF_DAY  = 5'd12;

  typedef enum logic [2:0] {
    PH_NONE     = 3'd0,
    PH_TIME_MIN = 3'd1,
    PH_TIME_HR  = 3'd2,
    PH_ALM_MIN  = 3'd3,
    PH_ALM_HR   = 3'd4
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] button;
    logic       held;
  } in_item_t;

  typedef struct packed {
    logic [4:0] hours_now;
    logic [5:0] minutes_now;
    logic [5:0] seconds_now;
    logic [2:0] weekday_now;
    logic [4:0] alarm_hour_out;
    logic [5:0] alarm_minute_out;
    logic       alarm_enabled;
    logic       ringing;
    logic [4:0] shown_hour;
    logic       twelve_hour_out;
    logic       fahrenheit_out;
    logic [2:0] adjust_phase_out;
  } out_item_t;

  typedef struct packed {
    logic [5:0] snooze_minutes;
    logic [4:0] alarm_minute_step;
  } cfg_t;

endpackage

// ----- sv/acwba_core.sv -----
// ----------------------------------------------------------------------------
// acwba_core
// clock and alarm state with the per-beat update and the result it produces
// ----------------------------------------------------------------------------
module acwba_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  acwba_pkg::in_item_t  item,
  input  acwba_pkg::cfg_t      cfg,
  output acwba_pkg::out_item_t res
);
  import acwba_pkg::*;

  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [2:0] wday_r, wday_nxt;
  logic [4:0] ahour_r, ahour_nxt;
  logic [5:0] amin_r, amin_nxt;
  logic       alarm_on_r, alarm_on_nxt;
  logic       beep_r, beep_nxt;
  logic       twelve_r, twelve_nxt;
  logic       fahr_r, fahr_nxt;
  phase_t     phase_r, phase_nxt;

  logic [6:0] step_sum;
  logic [6:0] snz_total;
  logic [5:0] snz_min;
  logic [1:0] snz_carry;
  logic [4:0] snz_hour;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r      <= 6'd0;
      min_r      <= 6'd45;
      hour_r     <= 5'd23;
      wday_r     <= 3'd0;
      ahour_r    <= 5'd0;
      amin_r     <= 6'd30;
      alarm_on_r <= 1'b0;
      beep_r     <= 1'b0;
      twelve_r   <= 1'b1;
      fahr_r     <= 1'b0;
      phase_r    <= PH_NONE;
    end else begin
      sec_r      <= sec_nxt;
      min_r      <= min_nxt;
      hour_r     <= hour_nxt;
      wday_r     <= wday_nxt;
      ahour_r    <= ahour_nxt;
      amin_r     <= amin_nxt;
      alarm_on_r <= alarm_on_nxt;
      beep_r     <= beep_nxt;
      twelve_r   <= twelve_nxt;
      fahr_r     <= fahr_nxt;
      phase_r    <= phase_nxt;
    end
  end

  // alarm minute step and snooze sums
  always_comb begin
    step_sum = {1'b0, amin_r} + {2'b00, cfg.alarm_minute_step};
    if (step_sum >= MIN_WRAP) begin
      step_sum = step_sum - MIN_WRAP;
    end
    snz_total = {1'b0, min_r} + {1'b0, cfg.snooze_minutes};
    priority if (snz_total >= MIN_WRAP2) begin
      snz_min   = 6'(snz_total - MIN_WRAP2);
      snz_carry = 2'd2;
    end else if (snz_total >= MIN_WRAP) begin
      snz_min   = 6'(snz_total - MIN_WRAP);
      snz_carry = 2'd1;
    end else begin
      snz_min   = snz_total[5:0];
      snz_carry = 2'd0;
    end
    snz_hour = hour_r + {3'b000, snz_carry};
    if (snz_hour >= HOUR_WRAP) begin
      snz_hour = snz_hour - HOUR_WRAP;
    end
  end

  always_comb begin
    sec_nxt      = sec_r;
    min_nxt      = min_r;
    hour_nxt     = hour_r;
    wday_nxt     = wday_r;
    ahour_nxt    = ahour_r;
    amin_nxt     = amin_r;
    alarm_on_nxt = alarm_on_r;
    beep_nxt     = beep_r;
    twelve_nxt   = twelve_r;
    fahr_nxt     = fahr_r;
    phase_nxt    = phase_r;
    if (fire) begin
      if (item.kind == KIND_TICK) begin
        beep_nxt = ~beep_r;
        if (sec_r >= SEC_LAST) begin
          sec_nxt = 6'd0;
          if (min_r >= MIN_LAST) begin
            min_nxt = 6'd0;
            if (hour_r >= HOUR_LAST) begin
              hour_nxt = 5'd0;
              wday_nxt = (wday_r >= WDAY_LAST) ? 3'd0 : wday_r + 3'd1;
            end else begin
              hour_nxt = hour_r + 5'd1;
            end
          end else begin
            min_nxt = min_r + 6'd1;
          end
        end else begin
          sec_nxt = sec_r + 6'd1;
        end
      end else begin
        unique case (item.button)
          BTN_MODE, BTN_ALARM: begin
            priority if (item.held) begin
              phase_nxt = (item.button == BTN_MODE) ? PH_TIME_MIN : PH_ALM_MIN;
            end else if (phase_r == PH_TIME_MIN) begin
              phase_nxt = PH_TIME_HR;
            end else if (phase_r == PH_ALM_MIN) begin
              phase_nxt = PH_ALM_HR;
            end else if (phase_r != PH_NONE) begin
              phase_nxt = PH_NONE;
            end else if (item.button == BTN_MODE) begin
              twelve_nxt = ~twelve_r;
            end else begin
              alarm_on_nxt = ~alarm_on_r;
            end
          end
          BTN_INCR: begin
            unique case (phase_r)
              PH_NONE:     fahr_nxt = ~fahr_r;
              PH_TIME_MIN: min_nxt = (min_r >= MIN_LAST) ? 6'd0 : min_r + 6'd1;
              PH_TIME_HR:  hour_nxt = (hour_r >= HOUR_LAST) ? 5'd0 : hour_r + 5'd1;
              PH_ALM_MIN:  amin_nxt = step_sum[5:0];
              PH_ALM_HR:   ahour_nxt = (ahour_r >= HOUR_LAST) ? 5'd0 : ahour_r + 5'd1;
              default:     fahr_nxt = fahr_r;
            endcase
          end
          BTN_SNOOZE: begin
            if (alarm_on_r) begin
              amin_nxt  = snz_min;
              ahour_nxt = snz_hour;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  always_comb begin
    res.hours_now        = hour_nxt;
    res.minutes_now      = min_nxt;
    res.seconds_now      = sec_nxt;
    res.weekday_now      = wday_nxt;
    res.alarm_hour_out   = ahour_nxt;
    res.alarm_minute_out = amin_nxt;
    res.alarm_enabled    = alarm_on_nxt;
    res.ringing          = alarm_on_nxt & beep_nxt & (hour_nxt == ahour_nxt) &
                           (min_nxt == amin_nxt);
    res.shown_hour       = (twelve_nxt && hour_nxt >= HALF_DAY) ? hour_nxt - HALF_DAY
                                                                : hour_nxt;
    res.twelve_hour_out  = twelve_nxt;
    res.fahrenheit_out   = fahr_nxt;
    res.adjust_phase_out = phase_nxt;
  end

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r <= SEC_LAST && min_r <= MIN_LAST && hour_r <= HOUR_LAST && wday_r <= WDAY_LAST)
    else $error("clock count out of range");

  a_alarm_range: assert property (@(posedge clk) disable iff (!rst_n)
    amin_r <= MIN_LAST && ahour_r <= HOUR_LAST)
    else $error("alarm setting out of range");

  a_tick_beep: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.kind == KIND_TICK |=> beep_r != $past(beep_r))
    else $error("beep phase did not toggle on tick");

  a_button_keeps_sec: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.kind == KIND_BUTTON |=> $stable(sec_r) && $stable(beep_r))
    else $error("button beat changed seconds or beep phase");

endmodule

// ----- sv/alarm_clock_with_button_adjust.sv -----
// ----------------------------------------------------------------------------
// alarm_clock_with_button_adjust
// alarm clock with time and alarm adjust, display modes and snooze
// ----------------------------------------------------------------------------
// Takes one beat per clock, either a one-second tick or a button press, and
// returns one result beat per input beat with the full clock status after
// that beat. Each beat passes an input register, then update logic against
// the clock state into the output register, and a new beat can be taken
// every cycle while the output is not stalled. Configuration writes are
// always ready and take effect on the next beat.
module alarm_clock_with_button_adjust (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  acwba_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output acwba_pkg::out_item_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [acwba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acwba_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import acwba_pkg::*;

  logic      in_vld_r;
  in_item_t  in_r;
  logic      out_vld_r;
  out_item_t out_r;
  cfg_t      cfg_r;
  out_item_t res;
  logic      adv;

  assign adv       = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall  = in_vld_r & ~adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.snooze_minutes    <= 6'd5;
      cfg_r.alarm_minute_step <= 5'd5;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SNOOZE: cfg_r.snooze_minutes    <= cfg_data[5:0];
        CFG_STEP:   cfg_r.alarm_minute_step <= cfg_data[4:0];
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  acwba_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (in_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  a_move_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !in_stall |=> out_vld_r)
    else $error("held beat did not reach output register");

endmodule
